### rtl/spdif_enc_pkg.sv
// Shared types and constants for the S/PDIF biphase-mark frame encoder.
// No dependencies; imported by spdif_enc_subframe and spdif_biphase_frame_encoder.
package spdif_enc_pkg;

    // Default number of frames in one channel-status block
    localparam int BLOCK_FRAMES_DEF = 192;

    // Preamble patterns, first UI in bit 7, for a line level of zero before them
    localparam logic [7:0] PRE_B = 8'hE8;
    localparam logic [7:0] PRE_M = 8'hE2;
    localparam logic [7:0] PRE_W = 8'hE4;

    // Subframe geometry
    localparam int SF_UI    = 64;
    localparam int SF_SLOTS = 28;

    // Input transaction: one stereo frame
    typedef struct packed {
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
    } t_in;

    // Result transaction: two coded subframes and the block marker
    typedef struct packed {
        logic [SF_UI-1:0] left_subframe;
        logic [SF_UI-1:0] right_subframe;
        logic             block_start;
    } t_out;

endpackage

### rtl/spdif_biphase_frame_encoder.sv
// S/PDIF biphase-mark frame encoder, top level.
// Depends on spdif_enc_pkg and spdif_enc_subframe.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one stereo
//   frame per transaction. Output channel (o_out_valid / i_out_stall /
//   o_out_data) carries the left and right 64-UI subframes, first UI in bit 63,
//   plus block_start, set when the left subframe opened a block with preamble B.
//   A transaction moves when valid is high and stall is low.
//   i_cfg_we / i_cfg_wdata write swap_halves, which exchanges the 16-bit halves
//   of each 32-bit word of both subframes; write it only while the block is idle.
// Timing:
//   One frame per cycle while the output is not stalled. A frame is captured into
//   the input register, coded in one pass between that register and the output
//   register, and offered on the output from there. The line level and the frame
//   counter advance as a frame moves into the output register.
// Reset (synchronous, i_rst_n low): both stages empty, line level low, frame
//   counter at zero (next frame starts a block), swap_halves cleared.
// Stall: while the output is stalled the result holds; one more frame can sit
//   in the input register, after which o_in_stall rises.
module spdif_biphase_frame_encoder #(
    parameter int BLOCK_FRAMES = spdif_enc_pkg::BLOCK_FRAMES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  spdif_enc_pkg::t_in   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output spdif_enc_pkg::t_out  o_out_data,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata
);
    import spdif_enc_pkg::*;

    localparam int IDX_W = (BLOCK_FRAMES > 1) ? $clog2(BLOCK_FRAMES) : 1;

    logic             r_s1_valid;
    t_in              r_s1_data;
    logic             r_out_valid;
    t_out             r_out_data;
    logic             r_line_level;
    logic [IDX_W-1:0] r_frame_idx;
    logic             r_swap;

    logic             w_in_accept;
    logic             w_s1_adv;
    logic             w_first;
    logic [SF_UI-1:0] w_left_sf;
    logic [SF_UI-1:0] w_right_sf;
    logic             w_left_level;
    logic             w_right_level;
    t_out             n_out;

    // Handshake: stage 1 drains into the output register when it is free
    assign w_s1_adv    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_s1_valid && !w_s1_adv;
    assign w_in_accept = i_in_valid && !o_in_stall;

    assign w_first = (r_frame_idx == '0);

    // Left then right subframe, line level chained between them
    spdif_enc_subframe u_left (
        .i_sample   (r_s1_data.left_sample),
        .i_preamble (w_first ? PRE_B : PRE_M),
        .i_level    (r_line_level),
        .o_subframe (w_left_sf),
        .o_level    (w_left_level)
    );

    spdif_enc_subframe u_right (
        .i_sample   (r_s1_data.right_sample),
        .i_preamble (PRE_W),
        .i_level    (w_left_level),
        .o_subframe (w_right_sf),
        .o_level    (w_right_level)
    );

    // Optional 16-bit half swap within each 32-bit word
    always_comb begin
        if (r_swap) begin
            n_out.left_subframe  = {w_left_sf[47:32], w_left_sf[63:48],
                                    w_left_sf[15:0], w_left_sf[31:16]};
            n_out.right_subframe = {w_right_sf[47:32], w_right_sf[63:48],
                                    w_right_sf[15:0], w_right_sf[31:16]};
        end else begin
            n_out.left_subframe  = w_left_sf;
            n_out.right_subframe = w_right_sf;
        end
        n_out.block_start = w_first;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_line_level <= 1'b0;
            r_frame_idx  <= '0;
            r_swap       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_swap <= i_cfg_wdata;
            end
            if (w_in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_out_valid  <= 1'b1;
                r_line_level <= w_right_level;
                if (r_frame_idx == IDX_W'(BLOCK_FRAMES - 1)) begin
                    r_frame_idx <= '0;
                end else begin
                    r_frame_idx <= r_frame_idx + IDX_W'(1);
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_s1_data <= i_in_data;
        end
        if (w_s1_adv) begin
            r_out_data <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Even parity keeps the slot count of zeros even, so the line returns low
    a_level_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> !r_line_level)
        else $error("line level left high after a frame");

    // Frame counter stays inside the block
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_frame_idx} < (IDX_W + 1)'(BLOCK_FRAMES))
        else $error("frame index beyond block length");

    // A frame leaving stage 1 at index zero is marked as block start
    a_block_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_adv && w_first) |=> (o_out_valid && o_out_data.block_start))
        else $error("block start not marked");

    // Input stalls only while stage 1 holds a frame that cannot move
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked frame");

endmodule

### rtl/spdif_enc_subframe.sv
// Biphase-mark coder for one 64-UI subframe: preamble, 28 slots, even parity.
// Purely combinational; depends on spdif_enc_pkg.
module spdif_enc_subframe (
    input  logic [15:0]                    i_sample,
    input  logic [7:0]                     i_preamble,
    input  logic                           i_level,
    output logic [spdif_enc_pkg::SF_UI-1:0] o_subframe,
    output logic                           o_level
);
    import spdif_enc_pkg::*;

    logic [7:0]          w_pre;
    logic                w_parity;
    logic                w_lvl0;
    logic [SF_SLOTS-1:0] w_bits;
    logic [SF_SLOTS-1:0] w_lvl;
    logic [SF_UI-9:0]    w_ui;

    // Preamble is inverted when the line sits high
    assign w_pre    = i_level ? ~i_preamble : i_preamble;
    assign w_lvl0   = w_pre[0];
    assign w_parity = ^i_sample;

    // Slot data, slot 0 in bit 0: zero low byte, sample LSB first, V U C, parity
    assign w_bits = {w_parity, 3'b000, i_sample, 8'h00};

    // Level entering each slot: every slot toggles, a one toggles back
    always_comb begin
        w_lvl = '0;
        w_ui  = '0;
        for (int s = 0; s < SF_SLOTS; s++) begin
            w_lvl[s] = w_lvl0 ^ 1'(s)
                     ^ (^(w_bits & ((SF_SLOTS'(1) << s) - SF_SLOTS'(1))));
            w_ui[SF_UI - 9 - 2 * s]  = ~w_lvl[s];
            w_ui[SF_UI - 10 - 2 * s] = ~w_lvl[s] ^ w_bits[s];
        end
    end

    assign o_subframe = {w_pre, w_ui};
    assign o_level    = ~w_lvl[SF_SLOTS-1] ^ w_bits[SF_SLOTS-1];

endmodule

### sim/tb_spdif_biphase_frame_encoder.sv
// Self-checking testbench for spdif_biphase_frame_encoder: predicts both coded subframes
// and the block marker of every frame and checks them against the output channel.
// Depends on spdif_enc_pkg and the encoder RTL.
module tb_spdif_biphase_frame_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    import spdif_enc_pkg::*;

    localparam int CHUNK_FRAMES = 230;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 80;
    localparam int HOLD_AT      = 60;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_stall = 1'b0;
    logic i_cfg_we    = 1'b0;
    logic i_cfg_wdata = 1'b0;
    t_in  i_in_data   = '0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;

    spdif_biphase_frame_encoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Frames waiting to be offered and coded frames waiting to come out
    t_in  frames_pending[$];
    t_out coded_frames[$];

    // Shadow of the encoder state and register
    logic swap_q     = 1'b0;
    logic line_lvl_q = 1'b0;
    int   frame_pos  = 0;

    int   idle_pct   = 0;
    int   stall_pct  = 0;
    int   n_errors   = 0;
    int   n_results  = 0;
    int   hold_left  = 0;
    bit   hold_done  = 1'b0;
    int   quiet_cyc  = 0;

    // Biphase-mark code one subframe; returns {line level after, subframe}
    function automatic logic [64:0] bmc_subframe(input logic [15:0] smp,
                                                 input logic [7:0]  pre,
                                                 input logic        lvl_in);
        logic [63:0] sf;
        logic [7:0]  pat;
        logic        lvl;
        logic        par;
        logic        dbit;
        logic        u1;
        logic        u2;
        sf  = '0;
        pat = lvl_in ? ~pre : pre;
        sf[63:56] = pat;
        lvl = pat[0];
        par = ^smp;
        for (int slot = 0; slot < SF_SLOTS; slot++) begin
            if (slot >= 8 && slot < 24) begin
                dbit = smp[slot-8];
            end else if (slot == SF_SLOTS - 1) begin
                dbit = par;
            end else begin
                dbit = 1'b0;
            end
            u1 = ~lvl;
            u2 = dbit ? lvl : u1;
            sf[55 - 2*slot] = u1;
            sf[54 - 2*slot] = u2;
            lvl = u2;
        end
        return {lvl, sf};
    endfunction

    function automatic logic [63:0] half_swap(input logic [63:0] v);
        return {v[47:32], v[63:48], v[15:0], v[31:16]};
    endfunction

    // Work out the coded frame for an accepted input and advance the shadow state
    task automatic code_frame(input t_in frm);
        t_out        res;
        logic [64:0] lr;
        logic        first;
        first = (frame_pos == 0);
        lr = bmc_subframe(frm.left_sample, first ? PRE_B : PRE_M, line_lvl_q);
        res.left_subframe = lr[63:0];
        lr = bmc_subframe(frm.right_sample, PRE_W, lr[64]);
        res.right_subframe = lr[63:0];
        line_lvl_q = lr[64];
        if (swap_q) begin
            res.left_subframe  = half_swap(res.left_subframe);
            res.right_subframe = half_swap(res.right_subframe);
        end
        res.block_start = first;
        frame_pos = (frame_pos + 1 >= BLOCK_FRAMES_DEF) ? 0 : frame_pos + 1;
        coded_frames.push_back(res);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        n_errors++;
    endtask

    // Driver: offers pending frames, holds a stalled transaction unchanged
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                code_frame(i_in_data);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (frames_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= frames_pending.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transaction, drives the output stall
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (coded_frames.size() == 0) begin
                    report_mismatch("unexpected result", 64'(o_out_data.block_start), 64'd0);
                end else begin
                    want = coded_frames.pop_front();
                    if (o_out_data.left_subframe !== want.left_subframe)
                        report_mismatch("left_subframe", o_out_data.left_subframe,
                                        want.left_subframe);
                    if (o_out_data.right_subframe !== want.right_subframe)
                        report_mismatch("right_subframe", o_out_data.right_subframe,
                                        want.right_subframe);
                    if (o_out_data.block_start !== want.block_start)
                        report_mismatch("block_start", 64'(o_out_data.block_start),
                                        64'(want.block_start));
                end
                n_results++;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // One long hold-off to back the pipeline up into the input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (n_results >= HOLD_AT && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cyc <= 0;
        end else if (quiet_cyc >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cyc <= quiet_cyc + 1;
        end
    end

    function automatic logic [15:0] rand_sample();
        logic [15:0] edge_vals[4];
        edge_vals = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
        if ($urandom_range(7) == 0)
            return edge_vals[$urandom_range(3)];
        return 16'($urandom);
    endfunction

    task automatic queue_frame(input logic [15:0] l, input logic [15:0] r);
        t_in frm;
        frm.left_sample  = l;
        frm.right_sample = r;
        frames_pending.push_back(frm);
    endtask

    // Wait until every frame is out, then let the pipeline settle
    task automatic drain();
        while (frames_pending.size() > 0 || i_in_valid || coded_frames.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_swap(input logic v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        swap_q = v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stimulus sequence
    initial begin
        int idle_tab[4];
        int stall_tab[4];
        idle_tab  = '{0, 72, 0, 8};
        stall_tab = '{0, 0, 72, 8};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_swap(1'b0);

        // directed: field extremes, parity patterns, single bits
        queue_frame(16'h0000, 16'h0000);
        queue_frame(16'h8000, 16'h7FFF);
        queue_frame(16'h7FFF, 16'h8000);
        queue_frame(16'hFFFF, 16'hFFFF);
        queue_frame(16'h5555, 16'hAAAA);
        queue_frame(16'hAAAA, 16'h5555);
        queue_frame(16'h0001, 16'h0000);
        queue_frame(16'h0000, 16'h0001);
        queue_frame(16'h0003, 16'h0007);
        queue_frame(16'h0100, 16'h8001);
        for (int b = 0; b < 12; b++)
            queue_frame(16'(1 << b), 16'(16'h8000 >> b));
        drain();
        write_swap(1'b1);
        queue_frame(16'h0000, 16'hFFFF);
        queue_frame(16'h8000, 16'h7FFF);
        queue_frame(16'h1234, 16'hFEDC);
        drain();

        // random frames across idle and stall phases and both swap settings
        for (int ph = 0; ph < 4; ph++) begin
            for (int sw = 0; sw < 2; sw++) begin
                write_swap(sw[0]);
                idle_pct  = idle_tab[ph];
                stall_pct = stall_tab[ph];
                for (int n = 0; n < CHUNK_FRAMES; n++)
                    queue_frame(rand_sample(), rand_sample());
                drain();
            end
        end

        idle_pct  = 0;
        stall_pct = 0;
        repeat (10) @(posedge i_clk);
        if (n_errors == 0 && coded_frames.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### spdif_biphase_frame_encoder.f
rtl/spdif_enc_pkg.sv
rtl/spdif_enc_subframe.sv
rtl/spdif_biphase_frame_encoder.sv
sim/tb_spdif_biphase_frame_encoder.sv
